### rtl/brf_pkg.sv
package brf_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PTR_W   = ADDR_W + 1;
    localparam int MAX_GET = 64;
    localparam int CNT_W   = 7;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       burst_start;
        logic [8:0] put_length;
        logic [6:0] get_length;
    } in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       last;
        logic [8:0] fill_level;
        logic       is_empty;
        logic       is_full;
    } out_t;

    // one classified item: a single result (optionally storing a byte) or a get run
    typedef struct packed {
        logic              is_get;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [CNT_W-1:0]  count;
        logic [1:0]        status;
        logic [8:0]        fill;
    } entry_t;

endpackage

### rtl/brf_front.sv
module brf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  brf_pkg::in_t    request,
    output brf_pkg::entry_t entry
);

    logic [brf_pkg::PTR_W-1:0] wptr_reg, wptr_next;
    logic [brf_pkg::PTR_W-1:0] rptr_reg, rptr_next;
    logic                      burst_reg, burst_next;

    logic [brf_pkg::PTR_W-1:0] fill;
    logic [brf_pkg::PTR_W-1:0] free_space;
    logic [8:0]                plen;
    logic [brf_pkg::CNT_W-1:0] glen;
    logic [brf_pkg::CNT_W-1:0] n;
    logic [brf_pkg::PTR_W-1:0] rptr_adv;
    logic                      store;

    always_comb
    begin
        fill       = wptr_reg - rptr_reg;
        free_space = brf_pkg::PTR_W'(brf_pkg::DEPTH) - fill;
        plen       = (request.put_length == 9'd0) ? 9'd1 : request.put_length;
        if (request.get_length == '0)
            glen = brf_pkg::CNT_W'(1);
        else if (request.get_length > brf_pkg::CNT_W'(brf_pkg::MAX_GET))
            glen = brf_pkg::CNT_W'(brf_pkg::MAX_GET);
        else
            glen = request.get_length;
        n        = (fill > brf_pkg::PTR_W'(glen)) ? glen : brf_pkg::CNT_W'(fill);
        rptr_adv = rptr_reg + brf_pkg::PTR_W'(n);

        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        burst_next = burst_reg;
        store      = 1'b0;

        entry.is_get = 1'b0;
        entry.wr_en  = 1'b0;
        entry.addr   = wptr_reg[brf_pkg::ADDR_W-1:0];
        entry.data   = request.data_byte;
        entry.count  = brf_pkg::CNT_W'(1);
        entry.status = brf_pkg::ST_OK;
        entry.fill   = 9'(fill);

        case (request.operation)
            brf_pkg::OP_PUT:
            begin
                if (request.burst_start)
                begin
                    if (free_space < brf_pkg::PTR_W'(plen))
                    begin
                        burst_next   = 1'b0;
                        entry.status = brf_pkg::ST_NOSPACE;
                    end
                    else
                    begin
                        burst_next = 1'b1;
                        store      = 1'b1;
                    end
                end
                else if (burst_reg && fill < brf_pkg::PTR_W'(brf_pkg::DEPTH))
                    store = 1'b1;
                else
                begin
                    burst_next   = 1'b0;
                    entry.status = brf_pkg::ST_NOSPACE;
                end
                if (store)
                begin
                    wptr_next   = wptr_reg + brf_pkg::PTR_W'(1);
                    entry.wr_en = 1'b1;
                    entry.fill  = 9'(fill + brf_pkg::PTR_W'(1));
                end
            end
            brf_pkg::OP_GET:
            begin
                if (fill == '0)
                    entry.status = brf_pkg::ST_EMPTY;
                else
                begin
                    entry.is_get = 1'b1;
                    entry.addr   = rptr_reg[brf_pkg::ADDR_W-1:0];
                    entry.count  = n;
                    entry.fill   = 9'(fill - brf_pkg::PTR_W'(n));
                    if (rptr_adv == wptr_reg)
                    begin
                        rptr_next = '0;
                        wptr_next = '0;
                    end
                    else
                        rptr_next = rptr_adv;
                end
            end
            brf_pkg::OP_CLEAR:
            begin
                wptr_next  = '0;
                rptr_next  = '0;
                burst_next = 1'b0;
                entry.fill = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            burst_reg <= 1'b0;
        end
        else if (accept)
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            burst_reg <= burst_next;
        end
    end

endmodule

### rtl/brf_queue.sv
module brf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  brf_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output brf_pkg::entry_t head
);

    brf_pkg::entry_t slots [2];
    logic            wr_idx_reg;
    logic            rd_idx_reg;
    logic [1:0]      count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slots[rd_idx_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_idx_reg <= !wr_idx_reg;
            if (pop)
                rd_idx_reg <= !rd_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_idx_reg] <= push_entry;
    end

endmodule

### rtl/brf_back.sv
module brf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  brf_pkg::entry_t head,
    output logic            pop,
    output logic            done,
    output brf_pkg::out_t   result
);

    logic [7:0] mem [brf_pkg::DEPTH];

    logic                       active_reg;
    logic [brf_pkg::CNT_W-1:0]  remain_reg;
    logic [brf_pkg::ADDR_W-1:0] raddr_reg;
    logic [8:0]                 run_fill_reg;

    logic                       s1_valid_reg;
    logic                       s1_get_reg;
    logic [1:0]                 s1_status_reg;
    logic                       s1_last_reg;
    logic [8:0]                 s1_fill_reg;
    logic [7:0]                 rd_reg;

    logic                       rd_en;
    logic                       wr_en;
    logic [brf_pkg::ADDR_W-1:0] rd_addr;

    assign pop     = !active_reg && head_valid;
    assign rd_en   = active_reg || (pop && head.is_get);
    assign wr_en   = pop && !head.is_get && head.wr_en;
    assign rd_addr = active_reg ? raddr_reg : head.addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head.addr] <= head.data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            remain_reg   <= '0;
            raddr_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= active_reg || pop;
            if (active_reg)
            begin
                raddr_reg  <= raddr_reg + brf_pkg::ADDR_W'(1);
                remain_reg <= remain_reg - brf_pkg::CNT_W'(1);
                if (remain_reg == brf_pkg::CNT_W'(1))
                    active_reg <= 1'b0;
            end
            else if (pop && head.is_get)
            begin
                raddr_reg  <= head.addr + brf_pkg::ADDR_W'(1);
                remain_reg <= head.count - brf_pkg::CNT_W'(1);
                active_reg <= (head.count != brf_pkg::CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            s1_get_reg    <= 1'b1;
            s1_status_reg <= brf_pkg::ST_OK;
            s1_last_reg   <= (remain_reg == brf_pkg::CNT_W'(1));
            s1_fill_reg   <= run_fill_reg;
        end
        else if (pop)
        begin
            s1_get_reg    <= head.is_get;
            s1_status_reg <= head.status;
            s1_last_reg   <= !head.is_get || (head.count == brf_pkg::CNT_W'(1));
            s1_fill_reg   <= head.fill;
            run_fill_reg  <= head.fill;
        end
    end

    assign done              = s1_valid_reg;
    assign result.read_byte  = s1_get_reg ? rd_reg : 8'd0;
    assign result.status     = s1_status_reg;
    assign result.last       = s1_last_reg;
    assign result.fill_level = s1_fill_reg;
    assign result.is_empty   = (s1_fill_reg == 9'd0);
    assign result.is_full    = (s1_fill_reg == 9'(brf_pkg::DEPTH));

endmodule

### rtl/byte_ring_fifo_burst.sv
// Byte FIFO with all-or-nothing put bursts over a 256-entry circular store. An item is
// taken when start is high and busy is low; busy rises only while the two-entry queue
// between the classifier and the executor is full. A put, clear or empty get gives one
// result; a get of n bytes gives n results on consecutive cycles, one store read per
// cycle, so puts sustain one item per cycle unless a get run holds the executor until
// its last byte is read. Each result appears on result for exactly one cycle with done
// high, registered after the queue and the executor; the receiver must take it then.
module byte_ring_fifo_burst (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  brf_pkg::in_t  request,
    output logic          done,
    output brf_pkg::out_t result
);

    brf_pkg::entry_t push_entry;
    brf_pkg::entry_t head;
    logic            accept;
    logic            q_full;
    logic            head_valid;
    logic            pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    brf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .entry   (push_entry)
    );

    brf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    brf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

    a_empty_get_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == brf_pkg::ST_EMPTY |-> result.last && result.is_empty)
        else $error("empty get result not final or fifo not empty");

    a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != brf_pkg::ST_OK |-> result.read_byte == 8'd0)
        else $error("error result carries data");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid && !done && !pop |=> !done)
        else $error("result without pending work");

endmodule
